// ===== design/thc_pkg.sv =====
// shared types and constants for the temperature/humidity compensation block
// no dependencies; used by thc_seq, temp_humidity_compensation and thc_checker
package thc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP_TRIM_ONE   = 3'd0;
	localparam logic [2:0] REG_TEMP_TRIM_TWO   = 3'd1;
	localparam logic [2:0] REG_TEMP_TRIM_THREE = 3'd2;
	localparam logic [2:0] REG_HUM_TRIM_TWO    = 3'd3;
	localparam logic [2:0] REG_HUM_TRIM_FOUR   = 3'd4;
	localparam logic [2:0] REG_HUM_TRIM_FIVE   = 3'd5;
	localparam logic [2:0] REG_HUM_TRIM_BYTES  = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int RAW_W      = 20;

	// calibration formula constants
	localparam logic [31:0] HUM_OFFSET   = 32'd76800;
	localparam logic [31:0] HUM_CLAMP    = 32'd419430400;
	localparam logic [31:0] HUM_ROUND    = 32'd16384;
	localparam logic [31:0] HUM_H3_BIAS  = 32'd32768;
	localparam logic [31:0] HUM_H6_BIAS  = 32'd2097152;
	localparam logic [31:0] HUM_H2_ROUND = 32'd8192;
	localparam logic [31:0] TEMP_ROUND   = 32'd128;

	// stored trim words, as written
	typedef struct packed {
		logic [15:0] temp_one;
		logic [15:0] temp_two;
		logic [15:0] temp_three;
		logic [15:0] hum_two;
		logic [11:0] hum_four;
		logic [11:0] hum_five;
		logic [23:0] hum_bytes;
	} thc_trim_t;

endpackage

// ===== design/thc_mul.sv =====
// shared 32x32 multiplier keeping the low 32 bits, product registered
// no dependencies
module thc_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [31:0] prod_q
);

	// low half of the product is the same for signed and unsigned operands
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 32'(op_a * op_b);
		end
	end

endmodule

// ===== design/thc_seq.sv =====
// step sequencer and datapath around the shared multiplier, output register
// depends on thc_pkg and thc_mul
module thc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  thc_pkg::thc_trim_t            trim,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [thc_pkg::RAW_W-1:0]     raw_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   comp_value,
	output logic                          is_humidity
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] T_M1    = 5'd1;
	localparam logic [4:0] T_P1    = 5'd2;
	localparam logic [4:0] T_M2    = 5'd3;
	localparam logic [4:0] T_P2    = 5'd4;
	localparam logic [4:0] T_M3    = 5'd5;
	localparam logic [4:0] T_P3    = 5'd6;
	localparam logic [4:0] T_FIN   = 5'd7;
	localparam logic [4:0] H_M1    = 5'd8;
	localparam logic [4:0] H_P1    = 5'd9;
	localparam logic [4:0] H_M2    = 5'd10;
	localparam logic [4:0] H_P2    = 5'd11;
	localparam logic [4:0] H_M3    = 5'd12;
	localparam logic [4:0] H_P3    = 5'd13;
	localparam logic [4:0] H_M4    = 5'd14;
	localparam logic [4:0] H_P4    = 5'd15;
	localparam logic [4:0] H_M5    = 5'd16;
	localparam logic [4:0] H_P5    = 5'd17;
	localparam logic [4:0] H_M6    = 5'd18;
	localparam logic [4:0] H_P6    = 5'd19;
	localparam logic [4:0] H_M7    = 5'd20;
	localparam logic [4:0] H_P7    = 5'd21;
	localparam logic [4:0] H_M8    = 5'd22;
	localparam logic [4:0] H_P8    = 5'd23;

	logic [4:0]                  step_q;
	logic                        hum_q;
	logic [thc_pkg::RAW_W-1:0]   raw_q;
	logic [31:0]                 fine_q;
	logic [31:0]                 r0_q;
	logic [31:0]                 r1_q;
	logic [31:0]                 a_q;
	logic                        out_valid_q;
	logic [31:0]                 comp_value_q;
	logic                        is_hum_q;

	logic                        mul_en;
	logic [31:0]                 op_a;
	logic [31:0]                 op_b;
	logic [31:0]                 prod_q;

	logic [31:0] t1;
	logic [31:0] t2s;
	logic [31:0] t3s;
	logic [31:0] tx1;
	logic [31:0] td;
	logic [31:0] tfine;
	logic [31:0] tsum;
	logic [31:0] h1;
	logic [31:0] h2s;
	logic [31:0] h3;
	logic [31:0] h5s;
	logic [31:0] h6s;
	logic [31:0] hv;
	logic [31:0] hq;
	logic [31:0] ha_sum;
	logic [31:0] hfin;
	logic [31:0] hclamp;
	logic        out_free;
	logic        finish;

	// trim values widened to 32 bits
	assign t1  = {16'd0, trim.temp_one};
	assign t2s = {{16{trim.temp_two[15]}}, trim.temp_two};
	assign t3s = {{16{trim.temp_three[15]}}, trim.temp_three};
	assign h1  = {24'd0, trim.hum_bytes[7:0]};
	assign h3  = {24'd0, trim.hum_bytes[15:8]};
	assign h6s = {{24{trim.hum_bytes[23]}}, trim.hum_bytes[23:16]};
	assign h2s = {{16{trim.hum_two[15]}}, trim.hum_two};
	assign h5s = {{20{trim.hum_five[11]}}, trim.hum_five};

	// temperature operands
	assign tx1   = {15'd0, raw_q[19:3]} - {15'd0, trim.temp_one, 1'b0};
	assign td    = {16'd0, raw_q[19:4]} - t1;
	assign tfine = r0_q + 32'($signed(prod_q) >>> 14);
	assign tsum  = {fine_q[29:0], 2'b00} + fine_q + thc_pkg::TEMP_ROUND;

	// humidity operands
	assign hv     = fine_q - thc_pkg::HUM_OFFSET;
	assign hq     = 32'($signed(r1_q) >>> 15);
	assign ha_sum = {2'b00, raw_q[15:0], 14'd0} - {trim.hum_four, 20'd0} - prod_q
		+ thc_pkg::HUM_ROUND;
	assign hfin   = r1_q - 32'($signed(prod_q) >>> 4);

	always_comb begin
		if (hfin[31]) begin
			hclamp = 32'd0;
		end else if (hfin > thc_pkg::HUM_CLAMP) begin
			hclamp = thc_pkg::HUM_CLAMP;
		end else begin
			hclamp = hfin;
		end
	end

	always_comb begin
		mul_en = 1'b0;
		op_a   = 32'd0;
		op_b   = 32'd0;
		case (step_q)
			T_M1: begin
				mul_en = 1'b1; op_a = tx1; op_b = t2s;
			end
			T_M2: begin
				mul_en = 1'b1; op_a = td; op_b = td;
			end
			T_M3: begin
				mul_en = 1'b1; op_a = r1_q; op_b = t3s;
			end
			H_M1: begin
				mul_en = 1'b1; op_a = h5s; op_b = hv;
			end
			H_M2: begin
				mul_en = 1'b1; op_a = hv; op_b = h6s;
			end
			H_M3: begin
				mul_en = 1'b1; op_a = hv; op_b = h3;
			end
			H_M4: begin
				mul_en = 1'b1; op_a = r0_q; op_b = r1_q;
			end
			H_M5: begin
				mul_en = 1'b1; op_a = r0_q; op_b = h2s;
			end
			H_M6: begin
				mul_en = 1'b1; op_a = a_q; op_b = r0_q;
			end
			H_M7: begin
				mul_en = 1'b1; op_a = hq; op_b = hq;
			end
			H_M8: begin
				mul_en = 1'b1; op_a = r0_q; op_b = h1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	thc_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign in_ready = (step_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	// last step waits here until the output register can take the result
	assign finish   = ((step_q == T_FIN) || (step_q == H_P8)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			fine_q      <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q <= req_type ? H_M1 : T_M1;
					end
				end
				T_P3: begin
					fine_q <= tfine;
					step_q <= T_FIN;
				end
				T_FIN, H_P8: begin
					if (out_free) begin
						step_q <= ST_IDLE;
					end
				end
				default: begin
					step_q <= 5'(step_q + 5'd1);
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			ST_IDLE: begin
				if (in_valid) begin
					hum_q <= req_type;
					raw_q <= raw_sample;
				end
			end
			T_P1: r0_q <= 32'($signed(prod_q) >>> 11);
			T_P2: r1_q <= 32'($signed(prod_q) >>> 12);
			H_P1: a_q  <= 32'($signed(ha_sum) >>> 15);
			H_P2: r0_q <= 32'($signed(prod_q) >>> 10);
			H_P3: r1_q <= 32'($signed(prod_q) >>> 11) + thc_pkg::HUM_H3_BIAS;
			H_P4: r0_q <= 32'($signed(prod_q) >>> 10) + thc_pkg::HUM_H6_BIAS;
			H_P5: r0_q <= 32'($signed(prod_q + thc_pkg::HUM_H2_ROUND) >>> 14);
			H_P6: r1_q <= prod_q;
			H_P7: r0_q <= 32'($signed(prod_q) >>> 7);
			default: begin
				r0_q <= r0_q;
			end
		endcase
		if (finish) begin
			is_hum_q     <= hum_q;
			comp_value_q <= hum_q ? {12'd0, hclamp[31:12]} : 32'($signed(tsum) >>> 8);
		end
	end

	assign out_valid   = out_valid_q;
	assign comp_value  = comp_value_q;
	assign is_humidity = is_hum_q;

endmodule

// ===== design/temp_humidity_compensation.sv =====
// top level: trim register file and the compensation sequencer
// depends on thc_pkg and thc_seq
//
//  channel  handshake            payload
//  in       in_valid/in_ready    req_type, raw_sample
//  out      out_valid/out_ready  comp_value, is_humidity
//  cfg      cfg_we               cfg_index, cfg_data
//
// a temperature request steps through T_M1..T_P3 and T_FIN after acceptance,
// a humidity request through H_M1..H_P8, all on one shared 32x32 multiplier
// in_ready is high only while the sequencer is idle; a new request is taken the
// cycle after the result enters the output register
// a result waiting on out_ready holds the last step and keeps in_ready low
// arst_n clears the trims, the kept fine temperature and the out_valid flag
module temp_humidity_compensation (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [thc_pkg::RAW_W-1:0]          raw_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [31:0]                 comp_value,
	output logic                               is_humidity,
	input  logic                               cfg_we,
	input  logic [thc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	thc_pkg::thc_trim_t trim_q;
	logic [31:0]        comp_value_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				thc_pkg::REG_TEMP_TRIM_ONE:   trim_q.temp_one   <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_TWO:   trim_q.temp_two   <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_THREE: trim_q.temp_three <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_TWO:    trim_q.hum_two    <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_FOUR:   trim_q.hum_four   <= cfg_data[11:0];
				thc_pkg::REG_HUM_TRIM_FIVE:   trim_q.hum_five   <= cfg_data[11:0];
				thc_pkg::REG_HUM_TRIM_BYTES:  trim_q.hum_bytes  <= cfg_data[23:0];
				default: begin
					trim_q <= trim_q;
				end
			endcase
		end
	end

	thc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.trim        (trim_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.raw_sample  (raw_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.comp_value  (comp_value_w),
		.is_humidity (is_humidity)
	);

	assign comp_value = $signed(comp_value_w);

endmodule

// ===== design/thc_checker.sv =====
// port-level checks for the compensation block, bound to the top level
// depends on thc_pkg and temp_humidity_compensation
module thc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               req_type,
	input logic [thc_pkg::RAW_W-1:0]          raw_sample,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [31:0]                 comp_value,
	input logic                               is_humidity
);

	// busy right after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after a request");

	// shortest computation is still running at the checked point, keeping in_ready low
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##3 !in_ready)
		else $error("request finished too early");

	// a new result only appears while a computation is running
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a running computation");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(comp_value)
			&& $stable(is_humidity)))
		else $error("stalled result changed");

	// waiting request holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(req_type)
			&& $stable(raw_sample)))
		else $error("waiting request changed");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (.*);
